>>> rtl/opd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the order-preserving duplicate filter.
package opd_pkg;

    localparam int ELEM_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int DEPTH_DEFAULT = 64;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     final_req;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_out;
        logic                     keep;
        logic [COUNT_W-1:0]       distinct_count;
        logic                     final_out;
        logic                     overflow;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

endpackage

>>> rtl/opd_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module opd_ram #(
    parameter int WIDTH = opd_pkg::ELEM_W,
    parameter int DEPTH = opd_pkg::DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/order_preserving_dedup.sv
`timescale 1ns / 1ps
// Top level of the order-preserving duplicate filter.
//
// Elements of one array arrive on the input channel (i_in_valid, o_in_stall,
// i_in_data), one per transfer, with final_req set on the last element.
// Every element yields exactly one result transfer on the output channel
// (o_out_valid, i_out_stall, o_out_data) carrying the element, a keep flag
// for its first occurrence, the running distinct count, the final flag and
// an overflow flag when a new value finds the store full.
// The distinct values seen so far sit in a RAM that one comparator scans,
// one entry per cycle. Each entry is compared against the registered RAM read
// data; once every held entry has been read with no match, a closing step
// moves on to the decide state, and a match ends the scan early. An empty store
// is not read at all. The result enters the output register in the decide state,
// and the next element is taken only after that, back in the idle state.
// Reset empties the store and clears both channels; the RAM needs no
// clearing because only entries below the count are ever read.
// A stalled result waits in the output register while the next element is
// already accepted and scanned; it is then held until the output is free.
module order_preserving_dedup #(
    parameter int DEPTH = opd_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  opd_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output opd_pkg::t_out  o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    opd_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_pend, n_pend;
    logic                       r_hit, n_hit;
    logic [opd_pkg::ELEM_W-1:0] r_elem, n_elem;
    logic                       r_final, n_final;
    logic                       r_out_valid, n_out_valid;
    opd_pkg::t_out              r_out, n_out;

    logic                       ram_we;
    logic                       ram_re;
    logic [opd_pkg::ELEM_W-1:0] ram_rdata;
    logic                       out_free;
    logic                       match;
    logic [CW-1:0]              new_count;

    opd_ram #(
        .WIDTH (opd_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_elem),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= opd_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem  <= n_elem;
        r_final <= n_final;
        r_out   <= n_out;
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign match     = r_pend && (ram_rdata == r_elem);
    assign new_count = (!r_hit && (r_count < CW'(DEPTH))) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_hit       = r_hit;
        n_elem      = r_elem;
        n_final     = r_final;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        o_in_stall  = 1'b1;

        case (r_state)
            opd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_elem  = i_in_data.element;
                    n_final = i_in_data.final_req;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = opd_pkg::ST_SCAN;
                end
            end
            opd_pkg::ST_SCAN: begin
                if (match) begin
                    n_hit   = 1'b1;
                    n_state = opd_pkg::ST_DECIDE;
                end else if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_state = opd_pkg::ST_DECIDE;
                end
            end
            opd_pkg::ST_DECIDE: begin
                if (out_free) begin
                    ram_we                  = !r_hit && (r_count < CW'(DEPTH));
                    n_out.element_out       = r_elem;
                    n_out.keep              = !r_hit;
                    n_out.distinct_count    = opd_pkg::COUNT_W'(new_count);
                    n_out.final_out         = r_final;
                    n_out.overflow          = !r_hit && (r_count == CW'(DEPTH));
                    n_out_valid             = 1'b1;
                    n_count                 = r_final ? '0 : new_count;
                    n_state                 = opd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = opd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sim/order_preserving_dedup_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the order-preserving duplicate filter with a built-in predictor.
module order_preserving_dedup_test;

    localparam int ELEM_W      = opd_pkg::ELEM_W;
    localparam int COUNT_W     = opd_pkg::COUNT_W;
    localparam int DEPTH       = opd_pkg::DEPTH_DEFAULT;
    localparam int ITEMS_TOTAL = 1950;
    localparam int HOLD_LEN    = 300;
    localparam int IDLE_LIMIT  = 5000;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           in_valid   = 1'b0;
    opd_pkg::t_in   in_data    = '0;
    logic           out_stall  = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    opd_pkg::t_out  o_out_data;

    logic [ELEM_W-1:0] seen_store [DEPTH];
    int                seen_n       = 0;
    opd_pkg::t_out     verdicts [$];
    opd_pkg::t_out     want;
    int                errors       = 0;
    int                items_sent   = 0;
    int                rx_wait      = 0;
    int                hold_left    = 0;
    logic              hold_req     = 1'b0;
    logic              tx_quiet     = 1'b0;
    logic              rx_quiet     = 1'b0;

    order_preserving_dedup #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic opd_pkg::t_out judge_element(input logic [ELEM_W-1:0] value,
                                                    input logic last);
        opd_pkg::t_out r;
        logic found;
        found = 1'b0;
        for (int i = 0; i < seen_n; i++) begin
            if (seen_store[i] == value) begin
                found = 1'b1;
            end
        end
        r.element_out = value;
        r.keep        = !found;
        r.final_out   = last;
        r.overflow    = 1'b0;
        if (!found) begin
            if (seen_n < DEPTH) begin
                seen_store[seen_n] = value;
                seen_n++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        r.distinct_count = COUNT_W'(seen_n);
        if (last) begin
            seen_n = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [ELEM_W-1:0] got,
                                   input logic [ELEM_W-1:0] expected);
        errors++;
        $display("MISMATCH %s: got %h, expected %h at %0t", field, got, expected, $realtime);
    endtask

    task automatic send_item(input logic [ELEM_W-1:0] value, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{element: value, final_req: last};
        do @(posedge i_clk); while (o_in_stall);
        verdicts.push_back(judge_element(value, last));
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls per transfer, plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
            if (verdicts.size() == 0) begin
                report_mismatch("unexpected transfer", o_out_data.element_out, '0);
            end else begin
                want = verdicts.pop_front();
                if (o_out_data.element_out !== want.element_out)
                    report_mismatch("element_out", o_out_data.element_out, want.element_out);
                if (o_out_data.keep !== want.keep)
                    report_mismatch("keep", ELEM_W'(o_out_data.keep), ELEM_W'(want.keep));
                if (o_out_data.distinct_count !== want.distinct_count)
                    report_mismatch("distinct_count", ELEM_W'(o_out_data.distinct_count),
                                    ELEM_W'(want.distinct_count));
                if (o_out_data.final_out !== want.final_out)
                    report_mismatch("final_out", ELEM_W'(o_out_data.final_out),
                                    ELEM_W'(want.final_out));
                if (o_out_data.overflow !== want.overflow)
                    report_mismatch("overflow", ELEM_W'(o_out_data.overflow),
                                    ELEM_W'(want.overflow));
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic test_extreme_values();
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b1);
        wait_for_results();
    endtask

    task automatic test_store_full();
        logic [ELEM_W-1:0] first;
        logic [ELEM_W-1:0] spare;
        first = ($urandom() & 32'hFFFF_FF80);
        send_item(first, 1'b0);
        for (int i = 1; i < DEPTH; i++) begin
            send_item(($urandom() & 32'hFFFF_FF80) | i, 1'b0);
        end
        spare = ($urandom() & 32'hFFFF_FF80) | 32'h40;
        send_item(spare, 1'b0);
        send_item(first, 1'b0);
        send_item(spare, 1'b0);
        send_item(($urandom() & 32'hFFFF_FF80) | 32'h41, 1'b1);
        send_item(first, 1'b1);
        for (int i = 0; i < DEPTH; i++) begin
            send_item(($urandom() & 32'hFFFF_FF80) | i, i == DEPTH - 1);
        end
        send_item(first, 1'b1);
        wait_for_results();
    endtask

    task automatic test_receiver_hold();
        tx_quiet = 1'b1;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_item($urandom_range(0, 3), i == 9);
        end
        wait_for_results();
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_arrays();
        logic [ELEM_W-1:0] pool [128];
        logic [ELEM_W-1:0] value;
        logic              long_array;
        int                len;
        int                pool_n;
        while (items_sent < ITEMS_TOTAL) begin
            long_array = ($urandom_range(0, 15) == 0);
            len    = long_array ? $urandom_range(60, 90) : $urandom_range(1, 24);
            pool_n = long_array ? $urandom_range(64, 100) : $urandom_range(1, 12);
            for (int k = 0; k < pool_n; k++) begin
                case ($urandom_range(0, 11))
                    0:       pool[k] = 32'h8000_0000;
                    1:       pool[k] = 32'h7FFF_FFFF;
                    2:       pool[k] = 32'h0000_0000;
                    3:       pool[k] = 32'hFFFF_FFFF;
                    default: pool[k] = $urandom();
                endcase
            end
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++) begin
                value = ($urandom_range(0, 7) == 0) ? $urandom()
                                                    : pool[$urandom_range(0, pool_n - 1)];
                send_item(value, k == len - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_for_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extreme_values();
        test_store_full();
        test_receiver_hold();
        test_random_arrays();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (verdicts.size() != 0) begin
            report_mismatch("results never delivered", ELEM_W'(verdicts.size()), '0);
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
